@@ design/sust_pkg.sv @@
// Shared types and constants for the sorted unique set table.
package sust_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 7;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                   was_present;
		logic                   full_reject;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic               cmp;
		logic               ins;
		logic               del;
		logic [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ design/sust_cell.sv @@
// One slot of the sorted table: holds an entry, compares it, shifts with its neighbors.
module sust_cell (
	input  logic                          clk,
	input  sust_pkg::cell_cmd_t           cmd,
	input  logic                          occupied,
	input  logic                          left_lt,
	input  logic [sust_pkg::VALUE_W-1:0]  left_entry,
	input  logic [sust_pkg::VALUE_W-1:0]  right_entry,
	output logic [sust_pkg::VALUE_W-1:0]  entry,
	output logic                          lt,
	output logic                          eq
);

	logic [sust_pkg::VALUE_W-1:0] entry_q;
	logic                         lt_q;
	logic                         eq_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_q <= occupied && (entry_q < cmd.value);
			eq_q <= occupied && (entry_q == cmd.value);
		end
		if (cmd.ins && !lt_q) begin
			entry_q <= left_lt ? cmd.value : left_entry;
		end else if (cmd.del && !lt_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

@@ design/sorted_unique_set_table.sv @@
// Top level of the sorted unique set table: cell row, count and result register.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | action, value
//  rsp     | out       | rsp_valid/stall   | was_present, full_reject, entry_count
//
// For each item the transfer cycle compares the value in every cell at once,
// then the shift cycle shifts the cell row and loads the result register.
// The shift cycle waits while a previous result is still stalled at rsp.
// Reset clears the count and the handshake state; cell contents are unknown.
// req_stall is high from a transfer until its result is loaded.
module sorted_unique_set_table #(
	parameter int CAPACITY = sust_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sust_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sust_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                         busy_q;
	sust_pkg::req_t               item_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         rsp_valid_q;
	sust_pkg::rsp_t               rsp_q;

	logic [sust_pkg::VALUE_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]          lt_vec;
	logic [CAPACITY-1:0]          eq_vec;

	logic                         req_xfer;
	logic                         done;
	logic                         present;
	logic                         full;
	logic                         add_go;
	logic                         rem_go;
	logic                         reject;
	logic [CNT_W-1:0]             cnt_next;
	sust_pkg::cell_cmd_t          cmd;

	assign req_xfer = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign done = busy_q && (!rsp_valid_q || !rsp_stall);

	assign present = |eq_vec;
	assign full    = cnt_q >= CNT_W'(CAPACITY);
	assign add_go  = done && (item_q.action == sust_pkg::ACT_ADD) && !present && !full;
	assign rem_go  = done && (item_q.action == sust_pkg::ACT_REMOVE) && present;
	assign reject  = (item_q.action == sust_pkg::ACT_ADD) && !present && full;

	always_comb begin
		cnt_next = cnt_q;
		if (add_go) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (rem_go) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		cmd.cmp   = req_xfer;
		cmd.ins   = add_go;
		cmd.del   = rem_go;
		cmd.value = req_xfer ? req.value : item_q.value;
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                         occ;
			logic                         l_lt;
			logic [sust_pkg::VALUE_W-1:0] l_entry;
			logic [sust_pkg::VALUE_W-1:0] r_entry;

			assign occ = CNT_W'(i) < cnt_q;
			if (i == 0) begin : g_first
				assign l_lt    = 1'b1;
				assign l_entry = req.value;
			end else begin : g_mid
				assign l_lt    = lt_vec[i-1];
				assign l_entry = entry[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign r_entry = entry[i];
			end else begin : g_inner
				assign r_entry = entry[i+1];
			end

			sust_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ),
				.left_lt     (l_lt),
				.left_entry  (l_entry),
				.right_entry (r_entry),
				.entry       (entry[i]),
				.lt          (lt_vec[i]),
				.eq          (eq_vec[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (req_xfer) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_q <= req;
		end
		if (done) begin
			rsp_q.was_present <= present;
			rsp_q.full_reject <= reject;
			rsp_q.entry_count <= sust_pkg::COUNT_OUT_W'(cnt_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(eq_vec))
		else $error("value matched in more than one cell");

	a_add_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		add_go |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("count did not grow on insert");

	a_rem_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rem_go |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("count did not shrink on delete");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.full_reject) |-> !rsp_q.was_present)
		else $error("reject flagged for a held value");

endmodule
